FILE: rtl/core/vdpr_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, register map and route codes for the voice mixer.
package vdpr_pkg;

  localparam int NUM_VOICES_DEF = 6;

  localparam int ADDR_W   = 6;
  localparam int ADDR_LSB = 3;
  localparam int DATA_W   = 64;
  localparam int IDX_W    = ADDR_W - ADDR_LSB;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [IDX_W-1:0] REG_RATES_0_3   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_RATES_4_5_G = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_ROUTES      = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_GAINS_0_1   = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_GAINS_2_3   = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_GAINS_4_5   = IDX_W'(5);

  localparam logic [63:0] RATES_0_3_RST   = 64'h8000_8000_8000_8000;
  localparam logic [47:0] RATES_4_5_G_RST = 48'h8000_8000_8000;

  localparam logic [2:0] ROUTE_DAC1_ST = 3'd0;
  localparam logic [2:0] ROUTE_DAC2_ST = 3'd1;
  localparam logic [2:0] ROUTE_DAC1_L  = 3'd2;
  localparam logic [2:0] ROUTE_DAC1_R  = 3'd3;
  localparam logic [2:0] ROUTE_DAC2_L  = 3'd4;
  localparam logic [2:0] ROUTE_DAC2_R  = 3'd5;

  localparam int CH_DAC1_L = 0;
  localparam int CH_DAC1_R = 1;
  localparam int CH_DAC2_L = 2;
  localparam int CH_DAC2_R = 3;

  typedef struct packed {
    logic [2:0]         voice;
    logic signed [15:0] sample;
    logic [3:0]         jack_present;
  } voice_req_t;

  typedef struct packed {
    logic signed [15:0] dac1_left;
    logic signed [15:0] dac1_right;
    logic signed [15:0] dac2_left;
    logic signed [15:0] dac2_right;
  } mix_req_t;

  typedef struct packed {
    logic [63:0]      rates_0_3;
    logic [47:0]      rates_4_5_g;
    logic [17:0]      routes;
    logic [2:0][63:0] gains;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         voice;
    logic               last;
    logic signed [15:0] sample;
    logic [2:0]         route;
    logic [31:0]        rate_prod;
    logic [15:0]        gain_l;
    logic [15:0]        gain_r;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: rtl/core/vdpr_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module vdpr_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vdpr_pkg::ADDR_W-1:0] paddr,
  input  logic [vdpr_pkg::DATA_W-1:0] pwdata,
  output logic [vdpr_pkg::DATA_W-1:0] prdata,
  output vdpr_pkg::cfg_t              cfg
);
  import vdpr_pkg::*;

  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign idx   = paddr[ADDR_W-1:ADDR_LSB];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rates_0_3   <= RATES_0_3_RST;
      cfg.rates_4_5_g <= RATES_4_5_G_RST;
      cfg.routes      <= '0;
      cfg.gains       <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_RATES_0_3:   cfg.rates_0_3   <= pwdata;
        REG_RATES_4_5_G: cfg.rates_4_5_g <= pwdata[47:0];
        REG_ROUTES:      cfg.routes      <= pwdata[17:0];
        REG_GAINS_0_1:   cfg.gains[0]    <= pwdata;
        REG_GAINS_2_3:   cfg.gains[1]    <= pwdata;
        REG_GAINS_4_5:   cfg.gains[2]    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RATES_0_3:   prdata = cfg.rates_0_3;
      REG_RATES_4_5_G: prdata = {16'b0, cfg.rates_4_5_g};
      REG_ROUTES:      prdata = {46'b0, cfg.routes};
      REG_GAINS_0_1:   prdata = cfg.gains[0];
      REG_GAINS_2_3:   prdata = cfg.gains[1];
      REG_GAINS_4_5:   prdata = cfg.gains[2];
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: rtl/core/vdpr_front.sv
`timescale 1ns / 1ps
// Front end: accepts voice requests, resolves routes, selects gains, forms rate product.
module vdpr_front #(
  parameter int NUM_VOICES = vdpr_pkg::NUM_VOICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 voice_valid,
  output logic                 voice_ready,
  input  vdpr_pkg::voice_req_t voice_req,
  input  vdpr_pkg::cfg_t       cfg,
  input  vdpr_pkg::q_stat_t    q_stat,
  output logic                 push,
  output vdpr_pkg::q_entry_t   entry
);
  import vdpr_pkg::*;

  localparam logic [2:0] LAST_VOICE  = 3'(NUM_VOICES - 1);
  localparam logic [2:0] VOICE_LIMIT = 3'(NUM_VOICES);

  logic        pending;
  logic        accept;
  logic        in_range;
  logic [15:0] rate;
  logic [15:0] glob;
  logic [63:0] greg;
  logic [2:0]  route_raw;
  q_entry_t    entry_next;

  function automatic logic [2:0] resolve_route(input logic [2:0] r, input logic [3:0] j);
    logic [2:0] res;
    res = r;
    unique case (r)
      ROUTE_DAC1_ST: res = (j[0] || j[1]) ? ROUTE_DAC1_ST : ROUTE_DAC2_ST;
      ROUTE_DAC2_ST: res = (j[2] || j[3]) ? ROUTE_DAC2_ST : ROUTE_DAC1_ST;
      ROUTE_DAC1_L: begin
        priority if (j[0]) res = ROUTE_DAC1_L;
        else if (j[1])     res = ROUTE_DAC1_R;
        else if (j[2])     res = ROUTE_DAC2_L;
        else if (j[3])     res = ROUTE_DAC2_R;
        else               res = r;
      end
      ROUTE_DAC1_R: begin
        priority if (j[1]) res = ROUTE_DAC1_R;
        else if (j[0])     res = ROUTE_DAC1_L;
        else if (j[2])     res = ROUTE_DAC2_L;
        else if (j[3])     res = ROUTE_DAC2_R;
        else               res = r;
      end
      ROUTE_DAC2_L: begin
        priority if (j[2]) res = ROUTE_DAC2_L;
        else if (j[3])     res = ROUTE_DAC2_R;
        else if (j[0])     res = ROUTE_DAC1_L;
        else if (j[1])     res = ROUTE_DAC1_R;
        else               res = r;
      end
      ROUTE_DAC2_R: begin
        priority if (j[3]) res = ROUTE_DAC2_R;
        else if (j[2])     res = ROUTE_DAC2_L;
        else if (j[1])     res = ROUTE_DAC1_R;
        else if (j[0])     res = ROUTE_DAC1_L;
        else               res = r;
      end
      default: res = r;
    endcase
    return res;
  endfunction

  assign voice_ready = !pending || !q_stat.full;
  assign accept      = voice_valid && voice_ready;
  assign push        = pending && !q_stat.full;
  assign in_range    = voice_req.voice < VOICE_LIMIT;
  assign glob        = cfg.rates_4_5_g[47:32];

  always_comb begin
    unique case (voice_req.voice)
      3'd0: begin
        rate      = cfg.rates_0_3[15:0];
        route_raw = cfg.routes[2:0];
      end
      3'd1: begin
        rate      = cfg.rates_0_3[31:16];
        route_raw = cfg.routes[5:3];
      end
      3'd2: begin
        rate      = cfg.rates_0_3[47:32];
        route_raw = cfg.routes[8:6];
      end
      3'd3: begin
        rate      = cfg.rates_0_3[63:48];
        route_raw = cfg.routes[11:9];
      end
      3'd4: begin
        rate      = cfg.rates_4_5_g[15:0];
        route_raw = cfg.routes[14:12];
      end
      3'd5: begin
        rate      = cfg.rates_4_5_g[31:16];
        route_raw = cfg.routes[17:15];
      end
      default: begin
        rate      = '0;
        route_raw = ROUTE_DAC1_ST;
      end
    endcase

    unique case (voice_req.voice[2:1])
      2'd0:    greg = cfg.gains[0];
      2'd1:    greg = cfg.gains[1];
      2'd2:    greg = cfg.gains[2];
      default: greg = '0;
    endcase

    entry_next.voice     = voice_req.voice;
    entry_next.last      = voice_req.voice == LAST_VOICE;
    entry_next.sample    = voice_req.sample;
    entry_next.route     = resolve_route(route_raw, voice_req.jack_present);
    entry_next.rate_prod = {16'b0, rate} * {16'b0, glob};
    entry_next.gain_l    = voice_req.voice[0] ? greg[47:32] : greg[15:0];
    entry_next.gain_r    = voice_req.voice[0] ? greg[63:48] : greg[31:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      pending <= in_range;
    end else if (push) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry <= entry_next;
    end
  end

endmodule

FILE: rtl/core/vdpr_queue.sv
`timescale 1ns / 1ps
// Short request queue between front end and mixing back end.
module vdpr_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vdpr_pkg::q_entry_t wr_entry,
  input  logic               pop,
  output vdpr_pkg::q_entry_t rd_entry,
  output vdpr_pkg::q_stat_t  q_stat
);
  import vdpr_pkg::*;

  q_entry_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = count == Q_CNT_W'(Q_DEPTH);
  assign q_stat.empty = count == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_entry     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

endmodule

FILE: rtl/core/vdpr_back.sv
`timescale 1ns / 1ps
// Back end: rate reducer, pan scaling and saturating channel accumulation.
module vdpr_back #(
  parameter int NUM_VOICES = vdpr_pkg::NUM_VOICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  vdpr_pkg::q_entry_t rd_entry,
  input  vdpr_pkg::q_stat_t  q_stat,
  output logic               pop,
  output logic               mix_valid,
  input  logic               mix_ready,
  output vdpr_pkg::mix_req_t mix_req
);
  import vdpr_pkg::*;

  localparam int          VW        = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam logic [32:0] PHASE_ONE = 33'h0_4000_0000;
  localparam logic [30:0] PHASE_MAX = 31'h7FFF_FFFF;

  logic adv;

  logic [30:0]        phase [NUM_VOICES];
  logic signed [15:0] held  [NUM_VOICES];
  logic [VW-1:0]      vidx;
  logic [32:0]        psum;
  logic [32:0]        pdec;
  logic               latch;
  logic [30:0]        phase_next;
  logic signed [15:0] h_next;

  logic               s2_valid;
  logic               s2_last;
  logic [2:0]         s2_route;
  logic signed [15:0] s2_h;
  logic [15:0]        s2_gl;
  logic [15:0]        s2_gr;

  logic               s3_valid;
  logic               s3_last;
  logic [2:0]         s3_route;
  logic signed [15:0] s3_h;
  logic signed [32:0] s3_pl;
  logic signed [32:0] s3_pr;

  logic               s4_valid;
  logic               s4_last;
  logic [3:0]         s4_en;
  logic signed [15:0] s4_c [4];

  logic signed [15:0] sl;
  logic signed [15:0] sr;
  logic [3:0]         en_next;
  logic signed [15:0] c_next [4];

  logic signed [15:0] sums      [4];
  logic signed [15:0] sums_next [4];

  // product >> 15 rounded toward zero, clamped to 16 bits
  function automatic logic signed [15:0] scale_sat(input logic signed [32:0] p);
    logic signed [32:0] adj;
    logic signed [17:0] q;
    logic signed [15:0] res;
    adj = p + (p[32] ? 33'sd32767 : 33'sd0);
    q   = adj[32:15];
    if (q[17:15] == 3'b000 || q[17:15] == 3'b111) begin
      res = q[15:0];
    end else begin
      res = q[17] ? 16'sh8000 : 16'sh7FFF;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] add_sat(input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
    logic signed [16:0] s;
    logic signed [15:0] res;
    s = 17'(a) + 17'(b);
    if (s[16] != s[15]) begin
      res = s[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      res = s[15:0];
    end
    return res;
  endfunction

  assign adv = !mix_valid || mix_ready;
  assign pop = adv && !q_stat.empty;

  // rate reducer
  always_comb begin
    vidx       = rd_entry.voice[VW-1:0];
    psum       = {2'b0, phase[vidx]} + {1'b0, rd_entry.rate_prod};
    latch      = psum[32:30] != 3'b000;
    pdec       = latch ? psum - PHASE_ONE : psum;
    phase_next = (pdec[32:31] != 2'b00) ? PHASE_MAX : pdec[30:0];
    h_next     = latch ? rd_entry.sample : held[vidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase[i] <= '0;
        held[i]  <= '0;
      end
    end else if (pop) begin
      phase[vidx] <= phase_next;
      held[vidx]  <= h_next;
    end
  end

  // route to channel contributions
  always_comb begin
    sl      = scale_sat(s3_pl);
    sr      = scale_sat(s3_pr);
    en_next = '0;
    for (int i = 0; i < 4; i++) begin
      c_next[i] = '0;
    end
    unique case (s3_route)
      ROUTE_DAC1_ST: begin
        en_next[CH_DAC1_L] = 1'b1;
        en_next[CH_DAC1_R] = 1'b1;
        c_next[CH_DAC1_L]  = sl;
        c_next[CH_DAC1_R]  = sr;
      end
      ROUTE_DAC2_ST: begin
        en_next[CH_DAC2_L] = 1'b1;
        en_next[CH_DAC2_R] = 1'b1;
        c_next[CH_DAC2_L]  = sl;
        c_next[CH_DAC2_R]  = sr;
      end
      ROUTE_DAC1_L: begin
        en_next[CH_DAC1_L] = 1'b1;
        c_next[CH_DAC1_L]  = s3_h;
      end
      ROUTE_DAC1_R: begin
        en_next[CH_DAC1_R] = 1'b1;
        c_next[CH_DAC1_R]  = s3_h;
      end
      ROUTE_DAC2_L: begin
        en_next[CH_DAC2_L] = 1'b1;
        c_next[CH_DAC2_L]  = s3_h;
      end
      ROUTE_DAC2_R: begin
        en_next[CH_DAC2_R] = 1'b1;
        c_next[CH_DAC2_R]  = s3_h;
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sums_next[i] = s4_en[i] ? add_sat(sums[i], s4_c[i]) : sums[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      mix_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sums[i] <= '0;
      end
    end else if (adv) begin
      s2_valid  <= pop;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      mix_valid <= s4_valid && s4_last;
      if (s4_valid) begin
        for (int i = 0; i < 4; i++) begin
          sums[i] <= s4_last ? 16'sd0 : sums_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_last  <= rd_entry.last;
      s2_route <= rd_entry.route;
      s2_h     <= h_next;
      s2_gl    <= rd_entry.gain_l;
      s2_gr    <= rd_entry.gain_r;

      s3_last  <= s2_last;
      s3_route <= s2_route;
      s3_h     <= s2_h;
      s3_pl    <= 33'(s2_h) * $signed({17'b0, s2_gl});
      s3_pr    <= 33'(s2_h) * $signed({17'b0, s2_gr});

      s4_last  <= s3_last;
      s4_en    <= en_next;
      for (int i = 0; i < 4; i++) begin
        s4_c[i] <= c_next[i];
      end

      if (s4_valid && s4_last) begin
        mix_req.dac1_left  <= sums_next[CH_DAC1_L];
        mix_req.dac1_right <= sums_next[CH_DAC1_R];
        mix_req.dac2_left  <= sums_next[CH_DAC2_L];
        mix_req.dac2_right <= sums_next[CH_DAC2_R];
      end
    end
  end

endmodule

FILE: rtl/core/voice_decimate_pan_route_mixer_unit.sv
`timescale 1ns / 1ps
// Top level: voice rate reducer, router and four-channel saturating mixer.
// Throughput: one voice request per cycle unless a held mix request stalls the back end;
//   one mix request per NUM_VOICES voices. Path of the last voice to mix_valid: front register,
//   queue slot, phase stage, multiply stage, scale stage, accumulate into the output register.
// A held mix request stalls the back end; the front register and queue take requests until full.
// Reset (synchronous, rst high): registers to defaults, phases, held samples and sums cleared.
module voice_decimate_pan_route_mixer_unit #(
  parameter int NUM_VOICES = vdpr_pkg::NUM_VOICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        voice_valid,
  output logic                        voice_ready,
  input  vdpr_pkg::voice_req_t        voice_req,
  output logic                        mix_valid,
  input  logic                        mix_ready,
  output vdpr_pkg::mix_req_t          mix_req,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vdpr_pkg::ADDR_W-1:0] paddr,
  input  logic [vdpr_pkg::DATA_W-1:0] pwdata,
  output logic [vdpr_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import vdpr_pkg::*;

  cfg_t     cfg;
  q_stat_t  q_stat;
  q_entry_t q_wr;
  q_entry_t q_rd;
  logic     q_push;
  logic     q_pop;

  assign pready = 1'b1;

  vdpr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  vdpr_front #(.NUM_VOICES(NUM_VOICES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .voice_valid (voice_valid),
    .voice_ready (voice_ready),
    .voice_req   (voice_req),
    .cfg         (cfg),
    .q_stat      (q_stat),
    .push        (q_push),
    .entry       (q_wr)
  );

  vdpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr),
    .pop      (q_pop),
    .rd_entry (q_rd),
    .q_stat   (q_stat)
  );

  vdpr_back #(.NUM_VOICES(NUM_VOICES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_entry  (q_rd),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .mix_valid (mix_valid),
    .mix_ready (mix_ready),
    .mix_req   (mix_req)
  );

  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("front pushed into a full queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !voice_ready |-> q_stat.full)
    else $error("front stalled while queue had room");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !mix_valid)
    else $error("mix request valid after reset");

endmodule
